// ===== hdl/swbm_pkg.sv =====
// ----------------------------------------------------------------------------
// swbm_pkg
// Shared widths, defaults and word layouts for the sliding-window
// background mean core.
// ----------------------------------------------------------------------------
package swbm_pkg;

    // field widths of the stream words
    localparam int SAMPLE_W     = 8;
    localparam int IDX_W        = 14;
    localparam int SEEN_W       = 32;
    localparam int WIN_CFG_W    = 6;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;

    // per-pixel running sum, saturating
    localparam int SUM_W        = 13;
    localparam int SUM_MAX      = 8191;

    // window register value after reset
    localparam int WINDOW_RESET = 25;

    // default sizing of the history store
    localparam int MAX_WINDOW_DEF = 32;
    localparam int PIXELS_DEF     = 16384;

    // result queue and divider slicing
    localparam int QUEUE_DEPTH  = 16;
    localparam int DIV_BITS     = 4;

    // one result word
    typedef struct packed {
        logic [SEEN_W-1:0]   frames_seen;
        logic [SAMPLE_W-1:0] background;
    } t_out_word;

endpackage

// ===== hdl/sliding_window_background_mean_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_background_mean_core
// Per-pixel mean of the last N frames, kept as a ring of past samples in one
// memory and a running sum per pixel in a second memory.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: sample, pixel_index
//                                               tlast: end_of_frame
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: background, frames_seen
//  cfg       in   i_cfg_valid/o_cfg_ready       data: window_length
//
//  One word per clock is accepted while the input is not stalled; a result
//  passes stage 0, stage 1, the divider pipe and the result queue. The sum
//  memory is read in the cycle before it is written back; a result of the
//  word just ahead on the same pixel is forwarded around the memory. After
//  reset and after every window write, a clearing pass zeroes the sum
//  memory, one entry per cycle, and no word is accepted. Output stalls fill
//  a 16-word result queue; the input also stalls when it is fully committed.
//
module sliding_window_background_mean_core #(
    parameter int MAX_WINDOW = swbm_pkg::MAX_WINDOW_DEF,
    parameter int PIXELS     = swbm_pkg::PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: [7:0] sample, [21:8] pixel_index, [23:22] zero
    input  logic [swbm_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: [7:0] background, [39:8] frames_seen
    output logic [swbm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // window_length write
    input  logic [swbm_pkg::WIN_CFG_W-1:0]      i_cfg_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready
);
    import swbm_pkg::*;

    // derived sizes
    localparam int CW          = $clog2(MAX_WINDOW + 1);
    localparam int HEAD_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PIX_W       = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int HIST_DEPTH  = MAX_WINDOW * PIXELS;
    localparam int HIST_AW     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int DIV_STAGES  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int PEND_W      = $clog2(QUEUE_DEPTH + 1);

    // index modulo PIXELS by reciprocal: q = (idx * RECIP) >> SHIFT
    localparam int SHIFT       = IDX_W + $clog2(PIXELS);
    localparam int MUL_W       = IDX_W + 2;
    localparam int PROD_W      = IDX_W + MUL_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(PIXELS) - 64'd1) / 64'(PIXELS);
    localparam logic [MUL_W-1:0]   RECIP      = MUL_W'(RECIP_FULL);
    localparam logic [HIST_AW-1:0] PIX_STRIDE = HIST_AW'(PIXELS);
    localparam logic [PIX_W-1:0]   PIX_LAST   = PIX_W'(PIXELS - 1);

    // one divider slot
    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  num;
        logic [CW-1:0]     rem;
        logic [CW-1:0]     cnt;
        logic [SEEN_W-1:0] seen;
    } t_div;

    // window value as used: zero acts as one, clipped to MAX_WINDOW
    function automatic logic [CW-1:0] f_window(input logic [WIN_CFG_W-1:0] w);
        logic [CW-1:0] res;
        if (w == '0) begin
            res = CW'(1);
        end else if (int'(w) > MAX_WINDOW) begin
            res = CW'(MAX_WINDOW);
        end else begin
            res = CW'(w);
        end
        return res;
    endfunction

    // frame and window state
    logic [CW-1:0]     r_win;
    logic [CW-1:0]     r_frames_held;
    logic [HEAD_W-1:0] r_head;
    logic [SEEN_W-1:0] r_total;
    logic              r_clr_busy;
    logic [PIX_W-1:0]  r_clr_addr;

    // handshakes
    logic in_acc;
    logic out_acc;
    logic cfg_acc;

    // input fields
    logic [SAMPLE_W-1:0] in_sample;
    logic [IDX_W-1:0]    in_idx;
    logic [PROD_W-1:0]   in_prod;

    // stage 0: index split, memory address
    logic                r_s0_valid;
    logic [SAMPLE_W-1:0] r_s0_smp;
    logic [IDX_W-1:0]    r_s0_idx;
    logic [IDX_W-1:0]    r_s0_q;
    logic [HEAD_W-1:0]   r_s0_head;
    logic                r_s0_full;
    logic [CW-1:0]       r_s0_cnt;
    logic [SEEN_W-1:0]   r_s0_seen;
    logic [PIX_W-1:0]    s0_pix;
    logic [HIST_AW-1:0]  s0_slot;

    // stage 1: sum update
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_smp;
    logic [PIX_W-1:0]    r_s1_pix;
    logic                r_s1_full;
    logic [CW-1:0]       r_s1_cnt;
    logic [SEEN_W-1:0]   r_s1_seen;
    logic [SUM_W-1:0]    s1_old;
    logic [SUM_W+1:0]    s1_wide;
    logic [SUM_W-1:0]    s1_sum;

    // memories and their read data
    logic [SAMPLE_W-1:0] r_hist_mem [HIST_DEPTH];
    logic [SUM_W-1:0]    r_sum_mem  [PIXELS];
    logic [SAMPLE_W-1:0] r_hist_rd;
    logic [SUM_W-1:0]    r_sum_rd;

    // forwarding of the word just written
    logic [PIX_W-1:0]    r_fwd_pix;

    // divider pipe
    t_div r_div [DIV_STAGES+1];
    t_div n_div [DIV_STAGES];

    // rounding
    logic [CW:0]         rnd_twice;
    logic                rnd_up;
    logic [SUM_W:0]      rnd_q;
    t_out_word           rnd_word;

    // result queue
    t_out_word           r_queue [QUEUE_DEPTH];
    logic [QAW:0]        r_wr_ptr;
    logic [QAW:0]        r_rd_ptr;
    logic [PEND_W-1:0]   r_pending;
    logic [PEND_W-1:0]   n_pending;
    logic                q_push;

    // handshakes
    assign o_cfg_ready     = 1'b1;
    assign cfg_acc         = i_cfg_valid;
    assign o_s_axis_tready = !r_clr_busy && (r_pending < PEND_W'(QUEUE_DEPTH));
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_wr_ptr != r_rd_ptr);
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = r_queue[r_rd_ptr[QAW-1:0]];

    assign in_sample = i_s_axis_tdata[SAMPLE_W-1:0];
    assign in_idx    = i_s_axis_tdata[SAMPLE_W +: IDX_W];
    assign in_prod   = PROD_W'(in_idx) * PROD_W'(RECIP);

    // frame counters, ring head, window register and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win         <= f_window(WIN_CFG_W'(WINDOW_RESET));
            r_frames_held <= '0;
            r_head        <= '0;
            r_total       <= '0;
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
        end else if (cfg_acc) begin
            r_win         <= f_window(i_cfg_data);
            r_frames_held <= '0;
            r_head        <= '0;
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + PIX_W'(1);
                if (r_clr_addr == PIX_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc && i_s_axis_tlast) begin
                if (CW'(r_head) + CW'(1) == r_win) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + HEAD_W'(1);
                end
                if (r_frames_held < r_win) begin
                    r_frames_held <= r_frames_held + CW'(1);
                end
                if (r_total != '1) begin
                    r_total <= r_total + SEEN_W'(1);
                end
            end
        end
    end

    // stage 0 capture at accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= in_acc;
        end
        r_s0_smp  <= in_sample;
        r_s0_idx  <= in_idx;
        r_s0_q    <= IDX_W'(in_prod >> SHIFT);
        r_s0_head <= r_head;
        r_s0_full <= (r_frames_held >= r_win);
        r_s0_cnt  <= (r_frames_held >= r_win) ? r_win : r_frames_held + CW'(1);
        r_s0_seen <= (r_total == '1) ? r_total : r_total + SEEN_W'(1);
    end

    // pixel position and ring slot
    always_comb begin
        s0_pix  = PIX_W'(r_s0_idx - IDX_W'(32'(r_s0_q) * 32'(PIXELS)));
        s0_slot = HIST_AW'(HIST_AW'(r_s0_head) * PIX_STRIDE) + HIST_AW'(s0_pix);
    end

    // sample ring: new sample written, evicted one read out
    always_ff @(posedge i_clk) begin
        if (r_s0_valid) begin
            r_hist_mem[s0_slot] <= r_s0_smp;
        end
        r_hist_rd <= r_hist_mem[s0_slot];
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
        r_s1_smp  <= r_s0_smp;
        r_s1_pix  <= s0_pix;
        r_s1_full <= r_s0_full;
        r_s1_cnt  <= r_s0_cnt;
        r_s1_seen <= r_s0_seen;
    end

    // sum update with forwarding and saturation
    always_comb begin
        if (r_div[0].valid && (r_fwd_pix == r_s1_pix)) begin
            s1_old = r_div[0].num;
        end else begin
            s1_old = r_sum_rd;
        end
        s1_wide = (SUM_W+2)'(s1_old) + (SUM_W+2)'(r_s1_smp)
                - (r_s1_full ? (SUM_W+2)'(r_hist_rd) : '0);
        if (s1_wide[SUM_W+1]) begin
            s1_sum = '0;
        end else if (s1_wide > (SUM_W+2)'(SUM_MAX)) begin
            s1_sum = SUM_W'(SUM_MAX);
        end else begin
            s1_sum = SUM_W'(s1_wide);
        end
    end

    // sum memory: read ahead, write back, or clear
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_sum_mem[r_clr_addr] <= '0;
        end else if (r_s1_valid) begin
            r_sum_mem[r_s1_pix] <= s1_sum;
        end
        r_sum_rd <= r_sum_mem[s0_pix];
    end

    // divider slices, restoring, DIV_BITS quotient bits each
    always_comb begin
        logic [CW:0] rem_sh;
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_div[k] = r_div[k];
            for (int j = 0; j < DIV_BITS; j++) begin
                if (k * DIV_BITS + j < SUM_W) begin
                    rem_sh = {n_div[k].rem, n_div[k].num[SUM_W-1]};
                    n_div[k].num = {n_div[k].num[SUM_W-2:0], 1'b0};
                    if (rem_sh >= {1'b0, n_div[k].cnt}) begin
                        rem_sh = rem_sh - {1'b0, n_div[k].cnt};
                        n_div[k].num[0] = 1'b1;
                    end
                    n_div[k].rem = rem_sh[CW-1:0];
                end
            end
        end
    end

    // divider pipe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_div[k].valid <= 1'b0;
            end
        end else begin
            r_div[0].valid <= r_s1_valid;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_div[k+1].valid <= n_div[k].valid;
            end
        end
        r_div[0].num  <= s1_sum;
        r_div[0].rem  <= '0;
        r_div[0].cnt  <= r_s1_cnt;
        r_div[0].seen <= r_s1_seen;
        r_fwd_pix     <= r_s1_pix;
        for (int k = 0; k < DIV_STAGES; k++) begin
            r_div[k+1].num  <= n_div[k].num;
            r_div[k+1].rem  <= n_div[k].rem;
            r_div[k+1].cnt  <= n_div[k].cnt;
            r_div[k+1].seen <= n_div[k].seen;
        end
    end

    // round to nearest, ties to even, clip to 8 bits
    always_comb begin
        rnd_twice = {r_div[DIV_STAGES].rem, 1'b0};
        rnd_up    = (rnd_twice > {1'b0, r_div[DIV_STAGES].cnt})
                 || ((rnd_twice == {1'b0, r_div[DIV_STAGES].cnt})
                     && r_div[DIV_STAGES].num[0]);
        rnd_q     = (SUM_W+1)'(r_div[DIV_STAGES].num) + (SUM_W+1)'(rnd_up);
        if (rnd_q > (SUM_W+1)'(255)) begin
            rnd_word.background = 8'hFF;
        end else begin
            rnd_word.background = SAMPLE_W'(rnd_q);
        end
        rnd_word.frames_seen = r_div[DIV_STAGES].seen;
        q_push = r_div[DIV_STAGES].valid;
    end

    // committed words: accepted and not yet taken
    always_comb begin
        n_pending = r_pending + PEND_W'(in_acc) - PEND_W'(out_acc);
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
            if (q_push) begin
                r_wr_ptr <= r_wr_ptr + (QAW+1)'(1);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + (QAW+1)'(1);
            end
        end
        if (q_push) begin
            r_queue[r_wr_ptr[QAW-1:0]] <= rnd_word;
        end
    end

`ifndef SYNTHESIS
    // a word in the queue is always one still counted as pending
    a_queue_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pending != '0))
        else $error("result queue holds a word not counted as pending");

    // the queue never overflows
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> ((r_wr_ptr - r_rd_ptr) < (QAW+1)'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    // frames held stays within the window
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_held <= r_win)
        else $error("frames held beyond window");

    // ring head stays inside the window
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_head) < r_win)
        else $error("ring head outside window");

    // no word enters while the sum memory is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s0_valid || $past(r_clr_busy) == 1'b0)
        else $error("word accepted during clearing pass");
`endif

endmodule
